// ===== rtl/pts_pkg.sv =====
// package: payload types, op and status codes for the task scheduler
package pts_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_LOCK    = 3'd3;
  localparam logic [2:0] OP_UNLOCK  = 3'd4;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_FULL          = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
  localparam logic [2:0] ST_ALREADY_OWNER = 3'd3;
  localparam logic [2:0] ST_NOT_OWNER     = 3'd4;
  localparam logic [2:0] ST_BLOCKED       = 3'd5;

  localparam logic [7:0]  PRIO_NONE        = 8'd255;
  localparam logic [15:0] DEADLINE_WIN_RST = 16'd50;
  localparam logic [7:0]  WATCHDOG_LIM_RST = 8'd100;

  localparam logic CFG_DEADLINE_WINDOW = 1'b0;
  localparam logic CFG_WATCHDOG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic [3:0]  requester_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        next_valid;
    logic [3:0]  next_slot;
    logic [15:0] miss_mask;
    logic        watchdog_timeout;
  } out_t;

endpackage

// ===== rtl/priority_task_scheduler_with_mutex.sv =====
// top level: task table, mutex and slot-scanning sequencer
//
// Usage: one item enters on the in channel (in_valid/in_ready, payload
// in_data), one result leaves on the out channel (out_valid/out_ready,
// payload out_data). Registers are written on the cfg channel: index 0
// deadline_window, index 1 watchdog_limit; always ready.
// Every item sweeps the table slot by slot with one comparator pass.
// Tick and release sweep the created slots for their own work (read,
// evaluate, write back), then a selection sweep (S_SEL, S_SELEV) follows.
// One item is in work at a time; in_ready is low meanwhile and rises in
// the cycle after the result beat.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new item.
// Reset clears the tick count, the task count, the mutex and the watchdog
// and restores the register defaults; table contents are not cleared, only
// slots below the task count are ever read. No clearing pass is needed.
module priority_task_scheduler_with_mutex
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_SELEV = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  typedef struct packed {
    logic [15:0] ident;
    logic [7:0]  prio;
    logic        ready;
    logic [31:0] deadline;
    logic        missed;
  } entry_t;

  logic [2:0]    state;
  in_t           item;
  logic [15:0]   deadline_window;
  logic [7:0]    watchdog_limit;
  logic [31:0]   tick_count;
  logic [CW-1:0] task_count;
  logic          mutex_locked;
  logic [SW-1:0] mutex_owner;
  logic [7:0]    saved_priority;
  logic          waiter_valid;
  logic [SW-1:0] waiter_slot;
  logic [7:0]    watchdog_count;

  // sweep bookkeeping
  logic [CW-1:0] idx;
  logic [1:0]    step;     // phase inside lock/unlock
  logic [7:0]    best;
  logic          sel_valid;
  logic [SW-1:0] sel_slot;
  logic [7:0]    req_prio;

  logic          we;
  logic [SW-1:0] addr;
  entry_t        wdata, rdata;

  pts_ram #(.WIDTH($bits(entry_t)), .DEPTH(1 << SW)) u_table (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  logic [SW-1:0] idx_s;
  assign idx_s = idx[SW-1:0];
  logic req_ok;
  assign req_ok = (32'(item.requester_slot) < 32'(task_count))
                  && (32'(item.requester_slot) < 32'(MAX_TASKS));
  logic [SW-1:0] req_s;
  assign req_s = SW'(item.requester_slot);

  logic [8:0] wd_next;
  assign wd_next = {1'b0, watchdog_count} + 9'd1;

  logic [31:0] rel_deadline;
  assign rel_deadline = tick_count + {16'd0, deadline_window};

  // table write and address
  always_comb begin
    we    = 1'b0;
    addr  = idx_s;
    wdata = rdata;
    unique case (state)
      S_RD, S_EVAL: begin
        // keep the slot addressed so the write-back sees its own entry
        if (item.op == OP_LOCK || item.op == OP_UNLOCK) begin
          addr = (step == 2'd1) ? mutex_owner
               : (step == 2'd2) ? waiter_slot : req_s;
        end
      end
      S_WR: begin
        unique case (item.op)
          OP_TICK: begin
            we = 1'b1;
            if (rdata.deadline != 32'd0 && tick_count >= rdata.deadline &&
                !rdata.missed) begin
              wdata.missed = 1'b1;
            end
          end
          OP_CREATE: begin
            we = 1'b1;
            addr = SW'(task_count);
            wdata.ident = item.task_id;
            wdata.prio = item.priority_req;
            wdata.ready = 1'b1;
            wdata.deadline = 32'd0;
            wdata.missed = 1'b0;
          end
          OP_RELEASE: begin
            we = 1'b1;
            wdata.ready = 1'b1;
            if (deadline_window != 16'd0) wdata.deadline = rel_deadline;
          end
          OP_LOCK: begin
            we = 1'b1;
            if (step == 2'd1) begin
              addr = mutex_owner;
              if (req_prio < rdata.prio) wdata.prio = req_prio;
            end else begin
              addr = req_s;
              wdata.ready = 1'b0;
            end
          end
          OP_UNLOCK: begin
            we = 1'b1;
            if (step == 2'd2) begin
              addr = waiter_slot;
              wdata.ready = 1'b1;
            end else begin
              addr = req_s;
              wdata.prio = saved_priority;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      deadline_window <= DEADLINE_WIN_RST;
      watchdog_limit  <= WATCHDOG_LIM_RST;
      tick_count      <= '0;
      task_count      <= '0;
      mutex_locked    <= 1'b0;
      mutex_owner     <= '0;
      saved_priority  <= '0;
      waiter_valid    <= 1'b0;
      waiter_slot     <= '0;
      watchdog_count  <= '0;
      idx             <= '0;
      step            <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_DEADLINE_WINDOW) deadline_window <= cfg_data;
        else watchdog_limit <= cfg_data[7:0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            idx  <= '0;
            step <= '0;
            out_data.status <= (in_data.op == OP_CREATE &&
                                32'(task_count) >= 32'(MAX_TASKS)) ? ST_FULL : ST_OK;
            out_data.next_valid <= 1'b0;
            out_data.next_slot <= '0;
            out_data.miss_mask <= '0;
            out_data.watchdog_timeout <= (in_data.op == OP_TICK) &&
                                         (wd_next > {1'b0, watchdog_limit});
            unique case (in_data.op)
              OP_TICK: begin
                tick_count <= tick_count + 32'd1;
                if (wd_next > {1'b0, watchdog_limit}) begin
                  watchdog_count <= '0;
                end else begin
                  watchdog_count <= wd_next[7:0];
                end
                state <= S_RD;
              end
              OP_CREATE: begin
                if (32'(task_count) >= 32'(MAX_TASKS)) begin
                  state <= S_SEL;
                end else begin
                  state <= S_WR;
                end
              end
              OP_RELEASE, OP_LOCK, OP_UNLOCK: state <= S_RD;
              default: state <= S_SEL;
            endcase
          end
        end
        S_RD: begin
          if ((item.op == OP_TICK || item.op == OP_RELEASE) && idx >= task_count) begin
            if (item.op == OP_RELEASE) out_data.status <= ST_NOT_FOUND;
            idx <= '0;
            state <= S_SEL;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (item.op)
            OP_TICK: begin
              if (rdata.deadline != 32'd0 && tick_count >= rdata.deadline &&
                  !rdata.missed && 32'(idx) < 32'd16) begin
                out_data.miss_mask[4'(idx)] <= 1'b1;
              end
              state <= S_WR;
            end
            OP_RELEASE: begin
              if (rdata.ident != item.task_id) begin
                idx <= idx + CW'(1);
                state <= S_RD;
              end else begin
                state <= S_WR;
              end
            end
            OP_LOCK: begin
              if (step == 2'd0) begin
                req_prio <= rdata.prio;
                if (!req_ok) begin
                  out_data.status <= ST_NOT_FOUND;
                  state <= S_SEL;
                end else if (!mutex_locked) begin
                  mutex_locked <= 1'b1;
                  mutex_owner <= req_s;
                  saved_priority <= rdata.prio;
                  state <= S_SEL;
                end else if (mutex_owner == req_s) begin
                  out_data.status <= ST_ALREADY_OWNER;
                  state <= S_SEL;
                end else begin
                  out_data.status <= ST_BLOCKED;
                  waiter_valid <= 1'b1;
                  waiter_slot <= req_s;
                  state <= S_WR;
                end
              end else begin
                state <= S_WR;
              end
            end
            OP_UNLOCK: begin
              if (step == 2'd0 && !req_ok) begin
                out_data.status <= ST_NOT_FOUND;
                state <= S_SEL;
              end else if (step == 2'd0 && (!mutex_locked || mutex_owner != req_s)) begin
                out_data.status <= ST_NOT_OWNER;
                state <= S_SEL;
              end else begin
                state <= S_WR;
              end
            end
            default: state <= S_SEL;
          endcase
        end
        S_WR: begin
          unique case (item.op)
            OP_TICK: begin
              idx <= idx + CW'(1);
              state <= S_RD;
            end
            OP_CREATE: begin
              task_count <= task_count + CW'(1);
              idx <= '0;
              state <= S_SEL;
            end
            OP_LOCK: begin
              idx <= '0;
              if (step == 2'd0) begin
                step <= 2'd1;
                state <= S_RD;
              end else begin
                state <= S_SEL;
              end
            end
            OP_UNLOCK: begin
              idx <= '0;
              if (step == 2'd0) begin
                mutex_locked <= 1'b0;
                mutex_owner <= '0;
                if (waiter_valid) begin
                  step <= 2'd2;
                  state <= S_RD;
                end else begin
                  waiter_slot <= '0;
                  state <= S_SEL;
                end
              end else begin
                waiter_valid <= 1'b0;
                waiter_slot <= '0;
                state <= S_SEL;
              end
            end
            default: begin
              idx <= '0;
              state <= S_SEL;
            end
          endcase
          if (item.op != OP_TICK) begin
            best <= PRIO_NONE;
            sel_valid <= 1'b0;
            sel_slot <= '0;
          end
        end
        S_SEL: begin
          if (item.op == OP_TICK || out_data.status != ST_OK ||
              item.op == OP_CREATE || idx == '0) begin
            if (idx == '0) begin
              best <= PRIO_NONE;
              sel_valid <= 1'b0;
              sel_slot <= '0;
            end
          end
          if (idx >= task_count) begin
            state <= S_OUT;
          end else begin
            state <= S_SELEV;
          end
        end
        S_SELEV: begin
          if (rdata.ready && rdata.prio < best) begin
            best <= rdata.prio;
            sel_valid <= 1'b1;
            sel_slot <= idx_s;
          end
          idx <= idx + CW'(1);
          state <= S_SEL;
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out_data.next_valid <= sel_valid;
            out_data.next_slot <= 4'(sel_slot);
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_no_in;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready;
  endproperty
  a_busy_no_in: assert property (p_busy_no_in) else $error("ready while busy");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(task_count) <= 32'(MAX_TASKS)) else $error("task count over limit");

  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");

  a_owner_free: assert property (@(posedge clk) disable iff (rst)
    !mutex_locked |-> mutex_owner == '0) else $error("free mutex with owner");

endmodule

// ===== rtl/pts_ram.sv =====
// generic single-port ram with registered read
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sim/priority_task_scheduler_with_mutex_tb.sv =====
// testbench: task scheduler with priority-inheritance mutex, predicted and checked per beat
`timescale 1ns / 100ps

module priority_task_scheduler_with_mutex_tb
  import pts_pkg::*;
();

  localparam int WATCHDOG_IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  priority_task_scheduler_with_mutex dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class sched_scoreboard;
    logic [15:0] win;
    logic [7:0]  wd_lim;
    logic [31:0] ticks;
    int          ntasks;
    logic [15:0] ident[16];
    logic [7:0]  prio[16];
    logic        rdy[16];
    logic [31:0] dl[16];
    logic        missed[16];
    logic        locked;
    logic [3:0]  owner;
    logic [7:0]  saved;
    logic        waiter_v;
    logic [3:0]  waiter;
    logic [7:0]  wd_cnt;
    out_t        pending[$];
    int          mismatches;

    function new();
      win = DEADLINE_WIN_RST;
      wd_lim = WATCHDOG_LIM_RST;
      ticks = 0;
      ntasks = 0;
      locked = 0;
      owner = 0;
      saved = 0;
      waiter_v = 0;
      waiter = 0;
      wd_cnt = 0;
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
        ident[i] = 0; prio[i] = 0; rdy[i] = 0; dl[i] = 0; missed[i] = 0;
      end
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_DEADLINE_WINDOW) win = val;
      else wd_lim = val[7:0];
    endfunction

    function void note_item(in_t it);
      out_t r;
      logic [8:0] nxt;
      int best;
      int k;
      r = '0;
      r.status = ST_OK;
      case (it.op)
        OP_TICK: begin
          ticks = ticks + 1;
          for (int i = 0; i < ntasks; i++)
            if (dl[i] != 0 && ticks >= dl[i] && !missed[i]) begin
              missed[i] = 1;
              r.miss_mask[i] = 1'b1;
            end
          nxt = {1'b0, wd_cnt} + 9'd1;
          if (nxt > {1'b0, wd_lim}) begin
            r.watchdog_timeout = 1;
            wd_cnt = 0;
          end else wd_cnt = nxt[7:0];
        end
        OP_CREATE: begin
          if (ntasks >= 16) r.status = ST_FULL;
          else begin
            ident[ntasks] = it.task_id; prio[ntasks] = it.priority_req;
            rdy[ntasks] = 1; dl[ntasks] = 0; missed[ntasks] = 0;
            ntasks++;
          end
        end
        OP_RELEASE: begin
          r.status = ST_NOT_FOUND;
          for (k = 0; k < ntasks; k++)
            if (ident[k] == it.task_id) break;
          if (k < ntasks) begin
            r.status = ST_OK;
            rdy[k] = 1;
            if (win != 0) dl[k] = ticks + 32'(win);
          end
        end
        OP_LOCK: begin
          k = it.requester_slot;
          if (k >= ntasks) r.status = ST_NOT_FOUND;
          else if (!locked) begin
            locked = 1; owner = k[3:0]; saved = prio[k];
          end else if (owner == k[3:0]) r.status = ST_ALREADY_OWNER;
          else begin
            rdy[k] = 0; waiter_v = 1; waiter = k[3:0];
            if (prio[k] < prio[owner]) prio[owner] = prio[k];
            r.status = ST_BLOCKED;
          end
        end
        OP_UNLOCK: begin
          k = it.requester_slot;
          if (k >= ntasks) r.status = ST_NOT_FOUND;
          else if (!locked || owner != k[3:0]) r.status = ST_NOT_OWNER;
          else begin
            prio[k] = saved; locked = 0; owner = 0;
            if (waiter_v) rdy[waiter] = 1;
            waiter_v = 0; waiter = 0;
          end
        end
        default: ;
      endcase
      best = PRIO_NONE;
      for (int i = 0; i < ntasks; i++)
        if (rdy[i] && prio[i] < best) begin
          best = prio[i]; r.next_valid = 1; r.next_slot = i[3:0];
        end
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.next_valid !== want.next_valid ||
          got.next_slot !== want.next_slot || got.miss_mask !== want.miss_mask ||
          got.watchdog_timeout !== want.watchdog_timeout) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d nv=%0b ns=%0d miss=%h wd=%0b",
                    " | got st=%0d nv=%0b ns=%0d miss=%h wd=%0b"},
                   want.status, want.next_valid, want.next_slot, want.miss_mask,
                   want.watchdog_timeout, got.status, got.next_valid, got.next_slot,
                   got.miss_mask, got.watchdog_timeout);
      end
    endfunction
  endclass

  sched_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver side: random stall and checking
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up after a beat when the next item follows at once
  task automatic send_item(in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain_results();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  function automatic in_t make_item(logic [2:0] op, logic [15:0] id, logic [7:0] p,
                                    logic [3:0] slot);
    in_t it;
    it.op = op; it.task_id = id; it.priority_req = p; it.requester_slot = slot;
    return it;
  endfunction

  // mostly valid ops on a small id set so release and the mutex get real work
  function automatic in_t random_item();
    int pick;
    logic [15:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    if (pick < 35) return make_item(OP_TICK, 16'($urandom), 8'($urandom), 4'($urandom));
    if (pick < 45) return make_item(OP_CREATE, id,
                                    ($urandom_range(9) == 0) ? PRIO_NONE : 8'($urandom),
                                    4'($urandom));
    if (pick < 65) return make_item(OP_RELEASE, id, 8'($urandom), 4'($urandom));
    if (pick < 80) return make_item(OP_LOCK, 16'($urandom), 8'($urandom), 4'($urandom));
    if (pick < 96) return make_item(OP_UNLOCK, 16'($urandom), 8'($urandom), 4'($urandom));
    return make_item(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom), 4'($urandom));
  endfunction

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = CFG_DEADLINE_WINDOW;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: requester not a task, then a small table through every op
    send_item(make_item(OP_LOCK, 16'h0, 8'h0, 4'd0));
    send_item(make_item(OP_UNLOCK, 16'h0, 8'h0, 4'd15));
    send_item(make_item(OP_RELEASE, 16'hFFFF, 8'h0, 4'd0));
    send_item(make_item(OP_CREATE, 16'hFFFF, PRIO_NONE, 4'd0));
    send_item(make_item(OP_CREATE, 16'h0000, 8'd0, 4'd0));
    send_item(make_item(OP_CREATE, 16'h1234, 8'd9, 4'd0));
    send_item(make_item(OP_CREATE, 16'h1234, 8'd3, 4'd0));
    send_item(make_item(OP_RELEASE, 16'h1234, 8'd0, 4'd0));
    send_item(make_item(OP_LOCK, 16'h0, 8'h0, 4'd1));
    send_item(make_item(OP_LOCK, 16'h0, 8'h0, 4'd1));
    send_item(make_item(OP_LOCK, 16'h0, 8'h0, 4'd2));
    send_item(make_item(OP_LOCK, 16'h0, 8'h0, 4'd0));
    send_item(make_item(OP_UNLOCK, 16'h0, 8'h0, 4'd2));
    send_item(make_item(OP_UNLOCK, 16'h0, 8'h0, 4'd1));
    send_item(make_item(OP_UNLOCK, 16'h0, 8'h0, 4'd1));
    send_item(make_item(3'd7, 16'hFFFF, 8'hFF, 4'hF));
    send_item(make_item(3'd5, 16'h0, 8'h0, 4'h0));
    for (int i = 0; i < 14; i++)
      send_item(make_item(OP_CREATE, 16'(i), 8'(200 - i), 4'd0));
    repeat (60) send_item(make_item(OP_TICK, 16'h0, 8'h0, 4'd0));

    // register extremes, then random phases on the now full table
    write_reg(CFG_DEADLINE_WINDOW, 16'd0);
    write_reg(CFG_WATCHDOG_LIMIT, 16'd0);
    send_item(make_item(OP_RELEASE, 16'h1234, 8'h0, 4'd0));
    repeat (4) send_item(make_item(OP_TICK, 16'h0, 8'h0, 4'd0));
    write_reg(CFG_DEADLINE_WINDOW, 16'hFFFF);
    write_reg(CFG_WATCHDOG_LIMIT, 16'hFF);
    send_item(make_item(OP_RELEASE, 16'h0, 8'h0, 4'd0));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_reg(CFG_DEADLINE_WINDOW, (ph == 4) ? 16'd1 : 16'($urandom_range(40)));
      write_reg(CFG_WATCHDOG_LIMIT, (ph == 5) ? 16'd1 : 16'($urandom_range(2, 30)));
      for (int n = 0; n < 170; n++) send_item(random_item());
    end

    drain_results();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
